// File: sv/tcf_pkg.sv
package tcf_pkg;

  localparam logic [7:0] IAC  = 8'd255;
  localparam logic [7:0] DONT = 8'd254;
  localparam logic [7:0] DO   = 8'd253;
  localparam logic [7:0] WONT = 8'd252;
  localparam logic [7:0] WILL = 8'd251;
  localparam logic [7:0] SB   = 8'd250;
  localparam logic [7:0] SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  localparam logic [7:0] CR   = 8'd13;
  localparam logic [7:0] LF   = 8'd10;
  localparam logic [7:0] NUL  = 8'd0;

  localparam int RUN_MAX = 3;

  typedef struct packed {
    logic [1:0]                cnt;
    logic                      to_client;
    logic [RUN_MAX-1:0][7:0]   bytes;
  } run_t;

endpackage

// File: sv/tcf_parser.sv
module tcf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output tcf_pkg::run_t     run
);

  typedef enum logic [2:0] {
    MODE_DATA    = 3'd0,
    MODE_CMD     = 3'd1,
    MODE_OPTION  = 3'd2,
    MODE_SUB     = 3'd3,
    MODE_SUB_IAC = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    VERB_DO   = 2'd0,
    VERB_DONT = 2'd1,
    VERB_WILL = 2'd2,
    VERB_WONT = 2'd3
  } verb_t;

  mode_t mode_r, mode_nxt;
  verb_t verb_r, verb_nxt;
  logic  cr_r, cr_nxt;

  always_comb begin
    mode_nxt = mode_r;
    verb_nxt = verb_r;
    cr_nxt   = 1'b0;
    run      = '0;
    case (mode_r)
      MODE_CMD: begin
        mode_nxt = MODE_DATA;
        case (byte_in)
          tcf_pkg::IAC: begin
            run.cnt      = 2'd1;
            run.bytes[0] = tcf_pkg::IAC;
          end
          tcf_pkg::DO: begin
            verb_nxt = VERB_DO;
            mode_nxt = MODE_OPTION;
          end
          tcf_pkg::DONT: begin
            verb_nxt = VERB_DONT;
            mode_nxt = MODE_OPTION;
          end
          tcf_pkg::WILL: begin
            verb_nxt = VERB_WILL;
            mode_nxt = MODE_OPTION;
          end
          tcf_pkg::WONT: begin
            verb_nxt = VERB_WONT;
            mode_nxt = MODE_OPTION;
          end
          tcf_pkg::SB: mode_nxt = MODE_SUB;
          default: mode_nxt = MODE_DATA;
        endcase
      end
      MODE_OPTION: begin
        mode_nxt = MODE_DATA;
        if (verb_r == VERB_DO && byte_in != tcf_pkg::OPT_ECHO
            && byte_in != tcf_pkg::OPT_SGA) begin
          run.cnt       = 2'd3;
          run.to_client = 1'b1;
          run.bytes[0]  = tcf_pkg::IAC;
          run.bytes[1]  = tcf_pkg::WONT;
          run.bytes[2]  = byte_in;
        end else if (verb_r == VERB_WILL && byte_in != tcf_pkg::OPT_SGA) begin
          run.cnt       = 2'd3;
          run.to_client = 1'b1;
          run.bytes[0]  = tcf_pkg::IAC;
          run.bytes[1]  = tcf_pkg::DONT;
          run.bytes[2]  = byte_in;
        end
      end
      MODE_SUB: begin
        if (byte_in == tcf_pkg::IAC) begin
          mode_nxt = MODE_SUB_IAC;
        end
      end
      MODE_SUB_IAC: begin
        mode_nxt = (byte_in == tcf_pkg::SE) ? MODE_DATA : MODE_SUB;
      end
      default: begin
        mode_nxt = MODE_DATA;
        if (byte_in == tcf_pkg::IAC) begin
          mode_nxt = MODE_CMD;
        end else if (byte_in == tcf_pkg::CR) begin
          run.cnt      = 2'd1;
          run.bytes[0] = byte_in;
          cr_nxt       = 1'b1;
        end else if (cr_r && (byte_in == tcf_pkg::NUL || byte_in == tcf_pkg::LF)) begin
          run.cnt = 2'd0;
        end else begin
          run.cnt      = 2'd1;
          run.bytes[0] = byte_in;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DATA;
      verb_r <= VERB_DO;
      cr_r   <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      verb_r <= verb_nxt;
      cr_r   <= cr_nxt;
    end
  end

endmodule

// File: sv/tcf_out_buf.sv
module tcf_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  tcf_pkg::run_t  run,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_to_client,
  output logic           out_last_of_run
);

  logic [tcf_pkg::RUN_MAX-1:0][7:0] byte_r;
  logic                             tc_r;
  logic [1:0]                       cnt_r;

  assign out_valid       = (cnt_r != 2'd0);
  assign out_byte        = byte_r[0];
  assign out_to_client   = tc_r;
  assign out_last_of_run = (cnt_r == 2'd1);
  assign can_load        = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= run.cnt;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= run.bytes;
      tc_r   <= run.to_client;
    end else if (out_valid && out_ready) begin
      byte_r[0] <= byte_r[1];
      byte_r[1] <= byte_r[2];
    end
  end

endmodule

// File: sv/telnet_command_filter.sv
// channel  ports                                              direction
// in       in_valid in_ready in_byte                          network -> block
// out      out_valid out_ready out_byte out_to_client         block -> sink
//          out_last_of_run
//
// One byte per cycle in; each byte leaves 0, 1 or 3 results, one per cycle,
// both unless stalled. Path: input register, then parse to result register.
// A 3-byte refusal holds the input register until its last result is taken.
// rst_n is synchronous; parser returns to data mode, both stages empty.
// A stalled out_ready backs up through the result register to in_ready.
module telnet_command_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_to_client,
  output logic       out_last_of_run
);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          can_load;
  logic          step;
  tcf_pkg::run_t run;

  assign step     = in_valid_r && can_load;
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  tcf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .run     (run)
  );

  tcf_out_buf u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step),
    .run             (run),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_to_client   (out_to_client),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: sv/tcf_checker.sv
module tcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_to_client,
  input logic       out_last_of_run
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("waiting input transaction dropped or changed");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled transaction dropped or changed");

  a_mid_run_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_to_client)
    else $error("multi-result run that is not a reply");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_to_client)
    else $error("reply run broken off");

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_byte         (in_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_to_client   (out_to_client),
  .out_last_of_run (out_last_of_run)
);
